@@ src/mmh_pkg.sv @@
`default_nettype none

package mmh_pkg;

  localparam int TYPE_W      = 2;
  localparam int VALUE_W     = 16;
  localparam int MASK_W      = 8;
  localparam int OFFSET_W    = 16;
  localparam int COUNT_W     = 31;
  localparam int SPAN_W      = 17;
  localparam int POS_W       = 20;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 1;

  localparam logic [MASK_W-1:0] MASK_MATCH = 8'd1;

  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [VALUE_W-1:0]  value_field_t;
  typedef logic [SPAN_W-1:0]   span_t;
  typedef logic [POS_W-1:0]    pos_field_t;

  typedef enum logic [TYPE_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_READ   = 2'd2
  } req_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SAMPLE_KIND = 1'b0,
    CFG_MASK_ENABLE = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIN_RD,
    ST_BIN_WR,
    ST_READ_RD,
    ST_READ_OUT
  } state_t;

  typedef struct packed {
    logic clear_init;
    logic clear_write;
    logic sample_take;
    logic latch_read;
    logic rd_bin;
    logic rd_read;
    logic wr_bin;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic counted;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ src/mmh_req_if.sv @@
`default_nettype none

interface mmh_req_if;
  logic                             valid;
  logic                             ready;
  logic [mmh_pkg::TYPE_W-1:0]       req_type;
  logic [mmh_pkg::VALUE_W-1:0]      sample_value;
  logic [mmh_pkg::MASK_W-1:0]       mask_byte;
  logic [mmh_pkg::OFFSET_W-1:0]     bin_offset;

  modport source (output valid, req_type, sample_value, mask_byte, bin_offset, input ready);
  modport sink   (input valid, req_type, sample_value, mask_byte, bin_offset, output ready);
endinterface

`default_nettype wire

@@ src/mmh_res_if.sv @@
`default_nettype none

interface mmh_res_if;
  logic                        valid;
  logic                        ready;
  mmh_pkg::count_t             bin_count;
  mmh_pkg::value_field_t       lowest_value;
  mmh_pkg::span_t              bin_span;
  mmh_pkg::pos_field_t         lowest_position;
  mmh_pkg::pos_field_t         highest_position;
  logic                        has_samples;

  modport source (output valid, bin_count, lowest_value, bin_span, lowest_position,
                  highest_position, has_samples, input ready);
  modport sink   (input valid, bin_count, lowest_value, bin_span, lowest_position,
                  highest_position, has_samples, output ready);
endinterface

`default_nettype wire

@@ src/mmh_cfg_if.sv @@
`default_nettype none

interface mmh_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mmh_pkg::CFG_INDEX_W-1:0]   index;
  logic [mmh_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/mmh_ctrl.sv @@
`default_nettype none

module mmh_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic [mmh_pkg::TYPE_W-1:0]  req_type,
  input  mmh_pkg::stat_t              stat,
  output logic                        req_ready,
  output mmh_pkg::cmd_t               cmd
);

  mmh_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmh_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      mmh_pkg::ST_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (stat.clear_last) begin
          state_next = mmh_pkg::ST_IDLE;
        end
      end
      mmh_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          unique case (req_type)
            mmh_pkg::REQ_CLEAR: begin
              cmd.clear_init = 1'b1;
              state_next     = mmh_pkg::ST_CLEAR;
            end
            mmh_pkg::REQ_SAMPLE: begin
              cmd.sample_take = 1'b1;
              if (stat.counted) begin
                state_next = mmh_pkg::ST_BIN_RD;
              end
            end
            mmh_pkg::REQ_READ: begin
              cmd.latch_read = 1'b1;
              state_next     = mmh_pkg::ST_READ_RD;
            end
            default: ;
          endcase
        end
      end
      mmh_pkg::ST_BIN_RD: begin
        cmd.rd_bin = 1'b1;
        state_next = mmh_pkg::ST_BIN_WR;
      end
      mmh_pkg::ST_BIN_WR: begin
        cmd.wr_bin = 1'b1;
        state_next = mmh_pkg::ST_IDLE;
      end
      mmh_pkg::ST_READ_RD: begin
        cmd.rd_read = 1'b1;
        state_next  = mmh_pkg::ST_READ_OUT;
      end
      mmh_pkg::ST_READ_OUT: begin
        if (stat.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = mmh_pkg::ST_IDLE;
        end
      end
      default: state_next = mmh_pkg::ST_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

@@ src/mmh_datapath.sv @@
`default_nettype none

module mmh_datapath #(
  parameter int VALUE_BITS    = 16,
  parameter int POSITION_BITS = 20,
  parameter int SAT_COUNT     = 2147483647
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mmh_pkg::VALUE_W-1:0]   sample_value,
  input  logic [mmh_pkg::MASK_W-1:0]    mask_byte,
  input  logic [mmh_pkg::OFFSET_W-1:0]  bin_offset,
  input  mmh_pkg::cmd_t                 cmd,
  output mmh_pkg::stat_t                stat,
  mmh_res_if.source                     res,
  mmh_cfg_if.sink                       cfg
);

  localparam int DEPTH = 1 << VALUE_BITS;
  localparam mmh_pkg::count_t SAT = mmh_pkg::COUNT_W'(SAT_COUNT);

  typedef logic [VALUE_BITS-1:0]    val_t;
  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [VALUE_BITS:0]      wide_span_t;

  localparam pos_t POS_MAX = '1;

  mmh_pkg::count_t mem [DEPTH];

  logic            sample_kind;
  logic            mask_enable;
  val_t            low_value;
  val_t            high_value;
  pos_t            low_pos;
  pos_t            high_pos;
  pos_t            position;
  logic            seen_any;
  val_t            bin_addr;
  logic [mmh_pkg::OFFSET_W-1:0] offset;
  val_t            clr_cnt;
  mmh_pkg::count_t rdata;
  logic            res_valid;

  logic [mmh_pkg::VALUE_W-1:0] v_in;
  val_t            v;
  logic            counted;
  val_t            read_addr;
  val_t            rd_addr;
  val_t            wr_addr;
  mmh_pkg::count_t wr_data;
  mmh_pkg::count_t inc;
  wide_span_t      span;
  mmh_pkg::span_t  span_out;
  logic            in_span;

  assign v_in    = sample_kind ? sample_value : {8'd0, sample_value[7:0]};
  assign v       = v_in[VALUE_BITS-1:0];
  assign counted = !mask_enable || (mask_byte == mmh_pkg::MASK_MATCH);

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_kind <= 1'b0;
      mask_enable <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mmh_pkg::CFG_SAMPLE_KIND: sample_kind <= cfg.data[0];
        mmh_pkg::CFG_MASK_ENABLE: mask_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // min/max trackers, first occurrence wins on ties
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_init) begin
      low_value  <= '0;
      high_value <= '0;
      low_pos    <= '0;
      high_pos   <= '0;
      seen_any   <= 1'b0;
      position   <= '0;
    end else if (cmd.sample_take) begin
      if (position != POS_MAX) begin
        position <= position + pos_t'(1);
      end
      if (counted) begin
        priority if (!seen_any) begin
          seen_any   <= 1'b1;
          low_value  <= v;
          high_value <= v;
          low_pos    <= position;
          high_pos   <= position;
        end else if (v < low_value) begin
          low_value <= v;
          low_pos   <= position;
        end else if (v > high_value) begin
          high_value <= v;
          high_pos   <= position;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_take) begin
      bin_addr <= v;
    end
    if (cmd.latch_read) begin
      offset <= bin_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_init) begin
      clr_cnt <= '0;
    end else if (cmd.clear_write) begin
      clr_cnt <= clr_cnt + val_t'(1);
    end
  end

  // bin store: one write port, one registered read port
  assign read_addr = low_value + offset[VALUE_BITS-1:0];
  assign rd_addr   = cmd.rd_read ? read_addr : bin_addr;
  assign inc       = (rdata < SAT) ? rdata + mmh_pkg::count_t'(1) : rdata;
  assign wr_addr   = cmd.clear_write ? clr_cnt : bin_addr;
  assign wr_data   = cmd.clear_write ? '0 : inc;

  always_ff @(posedge clk) begin
    if (cmd.clear_write || cmd.wr_bin) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_bin || cmd.rd_read) begin
      rdata <= mem[rd_addr];
    end
  end

  // result register
  assign span     = {1'b0, high_value} - {1'b0, low_value} + wide_span_t'(1);
  assign span_out = mmh_pkg::SPAN_W'(span);
  assign in_span  = {1'b0, offset} < span_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_result) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      res.bin_count        <= (seen_any && in_span) ? rdata : '0;
      res.lowest_value     <= seen_any ? mmh_pkg::VALUE_W'(low_value) : '0;
      res.bin_span         <= seen_any ? span_out : '0;
      res.lowest_position  <= seen_any ? mmh_pkg::POS_W'(low_pos) : '0;
      res.highest_position <= seen_any ? mmh_pkg::POS_W'(high_pos) : '0;
      res.has_samples      <= seen_any;
    end
  end

  assign res.valid = res_valid;

  assign stat.clear_last = (clr_cnt == '1);
  assign stat.counted    = counted;
  assign stat.out_free   = !res_valid || res.ready;

endmodule

`default_nettype wire

@@ src/masked_minmax_histogram.sv @@
`default_nettype none

// Histogram of 8- or 16-bit unsigned samples with optional masking, saturating
// bins and first-occurrence min/max tracking. Bins live in a single-port-write,
// registered-read RAM of 2^VALUE_BITS entries, so one transaction is handled at a
// time: a counted sample is accepted, then its bin is read, then written back; a
// masked-out sample or an unknown request is handled at acceptance alone; a read
// is accepted, reads its bin, then waits for the result register to drain before
// loading it. A clear request walks every bin, one per cycle; the same clearing
// pass runs after reset, during which no request is taken. Configuration writes are
// accepted at any time but must only be issued while idle.
module masked_minmax_histogram #(
  parameter int VALUE_BITS    = 16,
  parameter int POSITION_BITS = 20,
  parameter int SAT_COUNT     = 2147483647
) (
  input  logic      clk,
  input  logic      rst,
  mmh_req_if.sink   req,
  mmh_res_if.source res,
  mmh_cfg_if.sink   cfg
);

  mmh_pkg::cmd_t  cmd;
  mmh_pkg::stat_t stat;
  logic           req_ready;

  assign req.ready = req_ready;

  mmh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .stat      (stat),
    .req_ready (req_ready),
    .cmd       (cmd)
  );

  mmh_datapath #(
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS),
    .SAT_COUNT     (SAT_COUNT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .sample_value (req.sample_value),
    .mask_byte    (req.mask_byte),
    .bin_offset   (req.bin_offset),
    .cmd          (cmd),
    .stat         (stat),
    .res          (res),
    .cfg          (cfg)
  );

endmodule

`default_nettype wire
